// ===== rtl/lqs_pkg.sv =====
// ----------------------------------------------------------------------------
// lqs_pkg
// Types and codes for the linear queue with key search.
// ----------------------------------------------------------------------------
`default_nettype none

package lqs_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } lqs_op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } lqs_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DEL_RD,
    S_SCAN
  } lqs_state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } lqs_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_word;
    logic [2:0]         slot_found;
  } lqs_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic        load;
    logic        wr;
    logic        rd_head;
    logic        pop;
    logic        scan_init;
    logic        scan_step;
    logic        emit;
    lqs_status_e code;
    logic        use_word;
    logic        use_found;
  } lqs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    lqs_op_e op;
    logic    full;
    logic    empty;
    logic    match;
    logic    last;
  } lqs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/linear_queue_with_search_core.sv =====
// ----------------------------------------------------------------------------
// linear_queue_with_search_core
// Linear (non-circular) queue of signed 32-bit words with key search.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_i and raise start; the transfer happens at a rising
//   edge with start high and busy low. busy stays high while the item runs.
//   Result: done_o is high for exactly one cycle with rsp_o valid; the
//   receiver takes it in that cycle and cannot stall it.
// Sequence (states from the accepting edge to done_o):
//   insert, no-op, and rejected delete/search: S_EXEC only
//   delete: S_EXEC, then S_DEL_RD for the registered slot-memory read
//   search: S_EXEC, then S_SCAN over n = 1..DEPTH slots, one compare per cycle
//   through the single read port of the slot memory.
//   busy drops while done_o is shown, so the next request can be taken in
//   the same cycle.
// Reset: head and tail return to slot 0 (queue empty); slot contents are
//   not cleared and are only read once written.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_queue_with_search_core import lqs_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire lqs_req_t req_i,
  output logic          done_o,
  output lqs_rsp_t      rsp_o
);

  lqs_cmd_t  cmd;
  lqs_stat_t stat;

  lqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lqs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/lqs_datapath.sv =====
// ----------------------------------------------------------------------------
// lqs_datapath
// Slot memory, head/tail indices, scan index, key compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_datapath import lqs_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lqs_req_t  req_i,
  input  wire lqs_cmd_t  cmd_i,
  output lqs_stat_t      stat_o,
  output lqs_rsp_t       rsp_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = AW + 1;

  logic signed [31:0] slots_q [DEPTH];
  logic signed [31:0] rdata_q;
  logic signed [31:0] key_q;
  lqs_op_e            op_q;
  logic [AW-1:0]      head_q, head_d;
  logic [PW-1:0]      next_q, next_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic [PW-1:0]      head_inc;
  logic [PW-1:0]      idx_inc;
  logic [31:0]        idx_ext;
  lqs_rsp_t           rsp_q, rsp_d;

  assign head_inc = {1'b0, head_q} + PW'(1);
  assign idx_inc  = {1'b0, idx_q} + PW'(1);
  assign idx_ext  = {{(32-AW){1'b0}}, idx_q};

  assign stat_o.op    = op_q;
  assign stat_o.full  = (next_q == PW'(DEPTH));
  assign stat_o.empty = (next_q == '0) || ({1'b0, head_q} >= next_q);
  assign stat_o.match = (rdata_q == key_q);
  assign stat_o.last  = (idx_inc >= next_q);

  always_comb begin
    head_d = head_q;
    next_d = next_q;
    if (cmd_i.wr) begin
      next_d = next_q + PW'(1);
    end
    if (cmd_i.pop) begin
      if (head_inc >= next_q) begin
        head_d = '0;
        next_d = '0;
      end else begin
        head_d = head_inc[AW-1:0];
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan_init) begin
      idx_d = head_q;
    end else if (cmd_i.scan_step) begin
      idx_d = idx_inc[AW-1:0];
    end
  end

  assign rd_en   = cmd_i.rd_head | cmd_i.scan_init | cmd_i.scan_step;
  assign rd_addr = cmd_i.scan_step ? idx_inc[AW-1:0] : head_q;

  always_comb begin
    rsp_d            = rsp_q;
    if (cmd_i.emit) begin
      rsp_d.status     = cmd_i.code;
      rsp_d.read_word  = cmd_i.use_word ? rdata_q : '0;
      rsp_d.slot_found = cmd_i.use_found ? idx_ext[2:0] : 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      next_q <= '0;
    end else begin
      head_q <= head_d;
      next_q <= next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= lqs_op_e'(req_i.operation);
      key_q <= req_i.value;
    end
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      slots_q[next_q[AW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= slots_q[rd_addr];
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/lqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lqs_ctrl
// Sequencer for insert, delete and the slot-by-slot key scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_ctrl import lqs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  output logic           done_o,
  input  wire lqs_stat_t stat_i,
  output lqs_cmd_t       cmd_o
);

  lqs_state_e state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat_i.op)
          OP_DELETE: state_d = stat_i.empty ? S_IDLE : S_DEL_RD;
          OP_SEARCH: state_d = stat_i.empty ? S_IDLE : S_SCAN;
          OP_INSERT,
          OP_NOP:    state_d = S_IDLE;
        endcase
      end
      S_DEL_RD: state_d = S_IDLE;
      S_SCAN: begin
        if (stat_i.match || stat_i.last) state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.code = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_EXEC: begin
        unique case (stat_i.op)
          OP_INSERT: begin
            cmd_o.emit = 1'b1;
            if (stat_i.full) begin
              cmd_o.code = ST_FULL;
            end else begin
              cmd_o.wr = 1'b1;
            end
          end
          OP_DELETE: begin
            if (stat_i.empty) begin
              cmd_o.emit = 1'b1;
              cmd_o.code = ST_EMPTY;
            end else begin
              cmd_o.rd_head = 1'b1;
            end
          end
          OP_SEARCH: begin
            if (stat_i.empty) begin
              cmd_o.emit = 1'b1;
              cmd_o.code = ST_NOTFOUND;
            end else begin
              cmd_o.scan_init = 1'b1;
            end
          end
          OP_NOP: begin
            cmd_o.emit = 1'b1;
          end
        endcase
      end
      S_DEL_RD: begin
        cmd_o.emit     = 1'b1;
        cmd_o.use_word = 1'b1;
        cmd_o.pop      = 1'b1;
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.emit      = 1'b1;
          cmd_o.use_found = 1'b1;
        end else if (stat_i.last) begin
          cmd_o.emit = 1'b1;
          cmd_o.code = ST_NOTFOUND;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.emit;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/lqs_checker.sv =====
// ----------------------------------------------------------------------------
// lqs_checker
// Port-level checks on request/result sequencing of the queue core.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_checker import lqs_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start_i,
  input wire logic     busy_i,
  input wire logic     done_i,
  input wire lqs_rsp_t rsp_i
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("busy not raised after request transfer");

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(busy_i) && !busy_i)
    else $error("result strobe without a running request");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && (rsp_i.status != ST_DONE) |->
      (rsp_i.read_word == 32'sd0) && (rsp_i.slot_found == 3'd0))
    else $error("nonzero payload on a failed request");

endmodule

bind linear_queue_with_search_core lqs_checker u_lqs_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .done_i  (done_o),
  .rsp_i   (rsp_o)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the linear queue with key search against an in-bench queue model.
// Directed items cover empty, full, stale-head and duplicate-key cases.
// Random items drive fill and drain bursts with searches keyed mostly on
// stored words. Each result is compared field by field, in order.
// ----------------------------------------------------------------------------

module testbench;
  import lqs_pkg::*;

  localparam int QDEPTH = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic signed [31:0] FILL_WORDS [QDEPTH] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
    32'sh0000_0005, 32'sh0000_0005, 32'shAAAA_AAAA, 32'sh5555_5555
  };

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  lqs_req_t req;
  logic     done_o;
  lqs_rsp_t rsp_o;

  logic signed [31:0] q_slots [QDEPTH];
  int                 q_head;
  int                 q_tail;
  lqs_rsp_t           expected_rsps [$];
  int                 send_idle_pct;
  int                 fail_count;
  int                 cycle_count;

  linear_queue_with_search_core #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic lqs_rsp_t queue_response(input lqs_req_t item);
    lqs_rsp_t r;
    r = '0;
    case (lqs_op_e'(item.operation))
      OP_INSERT: begin
        if (q_tail >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          q_slots[q_tail] = item.value;
          q_tail++;
        end
      end
      OP_DELETE: begin
        if (q_head >= q_tail) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_word = q_slots[q_head];
          q_head++;
          if (q_head >= q_tail) begin
            q_head = 0;
            q_tail = 0;
          end
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (int s = q_head; s < q_tail; s++) begin
          if (q_slots[s] == item.value) begin
            r.status = ST_DONE;
            r.slot_found = 3'(s);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input lqs_op_e op, input logic signed [31:0] word);
    lqs_req_t item;
    item.operation = op;
    item.value = word;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req <= item;
    start <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_rsps.push_back(queue_response(item));
  endtask

  always @(posedge clk_i) begin : check_results
    lqs_rsp_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_rsps.size() == 0) begin
        $error("result with no transfer pending: status %0d read_word %0d slot_found %0d",
               rsp_o.status, rsp_o.read_word, rsp_o.slot_found);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          fail_count++;
        end
        if (rsp_o.read_word !== want.read_word) begin
          $error("read_word: expected %0d, got %0d", want.read_word, rsp_o.read_word);
          fail_count++;
        end
        if (rsp_o.slot_found !== want.slot_found) begin
          $error("slot_found: expected %0d, got %0d", want.slot_found, rsp_o.slot_found);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_item(OP_DELETE, 32'sh0);
    send_item(OP_SEARCH, 32'sh0);
    send_item(OP_NOP, 32'shFFFF_FFFF);
  endtask

  task automatic test_fill_overflow();
    for (int k = 0; k < QDEPTH; k++) begin
      send_item(OP_INSERT, FILL_WORDS[k]);
    end
    send_item(OP_INSERT, 32'sh1234_5678);
  endtask

  task automatic test_search_hits();
    send_item(OP_SEARCH, 32'sh8000_0000);
    send_item(OP_SEARCH, 32'sh5555_5555);
    send_item(OP_SEARCH, 32'sh0000_0005);
  endtask

  // full stays full after deletes until the queue drains to empty
  task automatic test_drain();
    repeat (3) send_item(OP_DELETE, 32'sh0);
    send_item(OP_SEARCH, 32'sh8000_0000);
    send_item(OP_INSERT, 32'sh0BAD_F00D);
    repeat (QDEPTH - 3) send_item(OP_DELETE, 32'sh0);
  endtask

  function automatic logic signed [31:0] pick_word(input lqs_op_e op);
    logic signed [31:0] pool [4];
    pool = '{32'sh0, 32'shFFFF_FFFF, 32'sh7, 32'sh8000_0000};
    if (op == OP_SEARCH && q_tail > q_head && $urandom_range(99) < 70)
      return q_slots[$urandom_range(q_tail - 1, q_head)];
    if (op != OP_NOP && $urandom_range(99) < 30)
      return pool[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int      fill_bias;
    int      span_left;
    int      pick;
    lqs_op_e op;
    send_idle_pct = idle_pct;
    span_left = 0;
    fill_bias = 50;
    for (int k = 0; k < n_items; k++) begin
      if (span_left == 0) begin
        fill_bias = $urandom_range(15, 85);
        span_left = $urandom_range(4, 24);
      end
      span_left--;
      pick = $urandom_range(99);
      if (pick < 4)
        op = OP_NOP;
      else if (pick < 30)
        op = OP_SEARCH;
      else if ($urandom_range(99) < fill_bias)
        op = OP_INSERT;
      else
        op = OP_DELETE;
      send_item(op, pick_word(op));
    end
  endtask

  initial begin
    q_head = 0;
    q_tail = 0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 26;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_queue();
    test_fill_overflow();
    test_search_hits();
    test_drain();
    test_random_traffic(350, 26);
    test_random_traffic(350, 47);
    test_random_traffic(350, 0);
    start <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
